// ----- hw/rtl/hiur_pkg.sv -----
// shared types and constants of the hex image upload receiver
package hiur_pkg;

    // default sizing
    localparam int MAX_IMAGE_BYTES_DEF = 16 * 1024;
    localparam int LINE_BYTES_DEF      = 64;
    localparam int Q_DEPTH             = 2;

    // result event codes
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_HDR_OK  = 3'd1;
    localparam logic [2:0] EV_HDR_BAD = 3'd2;
    localparam logic [2:0] EV_IMG_OK  = 3'd3;
    localparam logic [2:0] EV_LEN_BAD = 3'd4;
    localparam logic [2:0] EV_SUM_BAD = 3'd5;

    // header prefix progress: 0..3 chars matched, then header or not a header
    localparam logic [2:0] PF_NONE    = 3'd0;
    localparam logic [2:0] PF_ONE     = 3'd1;
    localparam logic [2:0] PF_HEADER  = 3'd4;
    localparam logic [2:0] PF_NOT_HDR = 3'd5;

    // number parsing phase
    localparam logic [2:0] NP_PRE_LEN = 3'd0;
    localparam logic [2:0] NP_LEN     = 3'd1;
    localparam logic [2:0] NP_PRE_SUM = 3'd2;
    localparam logic [2:0] NP_SUM     = 3'd3;
    localparam logic [2:0] NP_DONE    = 3'd4;

    // characters
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    localparam logic [31:0] DEC_BASE = 32'd10;

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic       nl;
        logic       cr;
        logic       nul;
        logic       bang;
        logic       space;
        logic       dec;
        logic [3:0] dval;
        logic       hex;
        logic [3:0] hval;
        logic [3:0] mk;     // match against each header marker position
    } t_cls;

    // one result beat
    typedef struct packed {
        logic [2:0]  event_res;
        logic        data_valid;
        logic [13:0] data_index;
        logic [7:0]  data_value;
        logic [14:0] image_length;
    } t_res;

endpackage

// ----- hw/rtl/hiur_front.sv -----
// front end: takes raw bytes and classifies them for the back end
module hiur_front import hiur_pkg::*; (
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cls       o_cls
);

    logic w_dec, w_lower, w_upper;

    assign w_dec   = (i_byte >= CH_0)  && (i_byte <= CH_9);
    assign w_lower = (i_byte >= CH_LA) && (i_byte <= CH_LF);
    assign w_upper = (i_byte >= CH_UA) && (i_byte <= CH_UF);

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        o_cls.nl    = (i_byte == CH_NL);
        o_cls.cr    = (i_byte == CH_CR);
        o_cls.nul   = (i_byte == CH_NUL);
        o_cls.bang  = (i_byte == CH_BANG);
        o_cls.space = (i_byte == CH_SPACE);
        o_cls.dec   = w_dec;
        o_cls.dval  = i_byte[3:0];
        o_cls.hex   = w_dec || w_lower || w_upper;
        // letters a-f and A-F both carry value low nibble plus nine
        o_cls.hval  = w_dec ? i_byte[3:0] : (i_byte[3:0] + 4'd9);
        o_cls.mk[0] = (i_byte == CH_BANG);
        o_cls.mk[1] = (i_byte == CH_S);
        o_cls.mk[2] = (i_byte == CH_L);
        o_cls.mk[3] = (i_byte == CH_T);
    end

endmodule

// ----- hw/rtl/hiur_queue.sv -----
// short queue of classified bytes between front and back
module hiur_queue import hiur_pkg::*; #(
    parameter int DEPTH = Q_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cls o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");
    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count past depth");
`endif

endmodule

// ----- hw/rtl/hiur_back.sv -----
// back end: line parser, body decoder and result register
module hiur_back import hiur_pkg::*; #(
    parameter int MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF,
    parameter int LINE_BYTES      = LINE_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cls i_cls,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    localparam int CW = $clog2(MAX_IMAGE_BYTES + 1);
    localparam int LW = $clog2(LINE_BYTES);
    localparam logic [LW-1:0] LINE_LAST = LW'(LINE_BYTES - 1);
    localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_IMAGE_BYTES);
    localparam logic [31:0]   MAX32     = 32'(MAX_IMAGE_BYTES);

    logic          r_in_body, n_in_body;
    logic [LW-1:0] r_line_count, n_line_count;
    logic          r_term, n_term;
    logic [2:0]    r_prefix, n_prefix;
    logic [2:0]    r_phase, n_phase;
    logic [31:0]   r_len_acc, n_len_acc;
    logic [31:0]   r_sum_acc, n_sum_acc;
    logic [CW-1:0] r_exp_len, n_exp_len;
    logic [31:0]   r_exp_sum, n_exp_sum;
    logic [CW-1:0] r_recv, n_recv;
    logic [31:0]   r_run_sum, n_run_sum;
    logic [3:0]    r_high, n_high;
    logic          r_nib_held, n_nib_held;
    logic [CW-1:0] r_acc_len, n_acc_len;
    logic          r_out_valid;
    t_res          r_out, n_out;

    logic [31:0] w_len_x10, w_sum_x10, w_idx32, w_acc32;
    logic [7:0]  w_byte;

    assign o_pop   = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    assign w_len_x10 = r_len_acc * DEC_BASE + 32'(i_cls.dval);
    assign w_sum_x10 = r_sum_acc * DEC_BASE + 32'(i_cls.dval);
    assign w_byte    = {r_high, i_cls.hval};
    assign w_idx32   = 32'(r_recv);
    assign w_acc32   = 32'(n_acc_len);

    always_comb begin
        n_in_body    = r_in_body;
        n_line_count = r_line_count;
        n_term       = r_term;
        n_prefix     = r_prefix;
        n_phase      = r_phase;
        n_len_acc    = r_len_acc;
        n_sum_acc    = r_sum_acc;
        n_exp_len    = r_exp_len;
        n_exp_sum    = r_exp_sum;
        n_recv       = r_recv;
        n_run_sum    = r_run_sum;
        n_high       = r_high;
        n_nib_held   = r_nib_held;
        n_acc_len    = r_acc_len;
        n_out.event_res  = EV_NONE;
        n_out.data_valid = 1'b0;
        n_out.data_index = '0;
        n_out.data_value = '0;

        if (!r_in_body) begin
            if (i_cls.nl || (r_line_count >= LINE_LAST)) begin
                if (r_prefix == PF_HEADER) begin
                    if ((r_len_acc == '0) || (r_len_acc > MAX32)) begin
                        n_out.event_res = EV_HDR_BAD;
                    end else begin
                        n_exp_len       = r_len_acc[CW-1:0];
                        n_exp_sum       = r_sum_acc;
                        n_recv          = '0;
                        n_run_sum       = '0;
                        n_nib_held      = 1'b0;
                        n_in_body       = 1'b1;
                        n_out.event_res = EV_HDR_OK;
                    end
                end
                n_line_count = '0;
                n_term       = 1'b0;
                n_prefix     = PF_NONE;
                n_phase      = NP_PRE_LEN;
                n_len_acc    = '0;
                n_sum_acc    = '0;
            end else if (!i_cls.cr) begin
                n_line_count = r_line_count + 1'b1;
                if (!r_term) begin
                    if (i_cls.nul) begin
                        n_term = 1'b1;
                    end else if (r_prefix < PF_HEADER) begin
                        n_prefix = i_cls.mk[r_prefix[1:0]] ? r_prefix + 3'd1 : PF_NOT_HDR;
                    end else if (r_prefix == PF_HEADER) begin
                        unique case (r_phase)
                            NP_PRE_LEN: begin
                                if (i_cls.dec) begin
                                    n_len_acc = 32'(i_cls.dval);
                                    n_phase   = NP_LEN;
                                end else if (!i_cls.space) begin
                                    n_phase = NP_DONE;
                                end
                            end
                            NP_LEN: begin
                                if (i_cls.dec) begin
                                    n_len_acc = w_len_x10;
                                end else begin
                                    n_phase = i_cls.space ? NP_PRE_SUM : NP_DONE;
                                end
                            end
                            NP_PRE_SUM: begin
                                if (i_cls.dec) begin
                                    n_sum_acc = 32'(i_cls.dval);
                                    n_phase   = NP_SUM;
                                end else if (!i_cls.space) begin
                                    n_phase = NP_DONE;
                                end
                            end
                            NP_SUM: begin
                                if (i_cls.dec) begin
                                    n_sum_acc = w_sum_x10;
                                end else begin
                                    n_phase = NP_DONE;
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
            end
        end else if (i_cls.bang) begin
            // the closing mark also opens the next line as its first char
            n_in_body    = 1'b0;
            n_nib_held   = 1'b0;
            n_term       = 1'b0;
            n_phase      = NP_PRE_LEN;
            n_len_acc    = '0;
            n_sum_acc    = '0;
            n_line_count = LW'(1);
            n_prefix     = PF_ONE;
            if (r_recv != r_exp_len) begin
                n_out.event_res = EV_LEN_BAD;
            end else if (r_run_sum != r_exp_sum) begin
                n_out.event_res = EV_SUM_BAD;
            end else begin
                n_acc_len       = r_recv;
                n_out.event_res = EV_IMG_OK;
            end
        end else if (i_cls.hex) begin
            if (!r_nib_held) begin
                n_high     = i_cls.hval;
                n_nib_held = 1'b1;
            end else begin
                n_nib_held = 1'b0;
                if (r_recv < MAX_CNT) begin
                    n_out.data_valid = 1'b1;
                    n_out.data_index = w_idx32[13:0];
                    n_out.data_value = w_byte;
                    n_recv           = r_recv + 1'b1;
                    n_run_sum        = r_run_sum + 32'(w_byte);
                end
            end
        end

        n_out.image_length = w_acc32[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_body    <= 1'b0;
            r_line_count <= '0;
            r_term       <= 1'b0;
            r_prefix     <= PF_NONE;
            r_phase      <= NP_PRE_LEN;
            r_len_acc    <= '0;
            r_sum_acc    <= '0;
            r_exp_len    <= '0;
            r_exp_sum    <= '0;
            r_recv       <= '0;
            r_run_sum    <= '0;
            r_high       <= '0;
            r_nib_held   <= 1'b0;
            r_acc_len    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_in_body    <= n_in_body;
                r_line_count <= n_line_count;
                r_term       <= n_term;
                r_prefix     <= n_prefix;
                r_phase      <= n_phase;
                r_len_acc    <= n_len_acc;
                r_sum_acc    <= n_sum_acc;
                r_exp_len    <= n_exp_len;
                r_exp_sum    <= n_exp_sum;
                r_recv       <= n_recv;
                r_run_sum    <= n_run_sum;
                r_high       <= n_high;
                r_nib_held   <= n_nib_held;
                r_acc_len    <= n_acc_len;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_data_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.data_valid) |-> (r_out.event_res == EV_NONE))
        else $error("data beat carries an event");
    a_body_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_in_body) |-> (r_out_valid && (r_out.event_res == EV_HDR_OK)))
        else $error("body opened without header accept");
    a_body_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_in_body) |-> (r_out_valid && ((r_out.event_res == EV_IMG_OK)
            || (r_out.event_res == EV_LEN_BAD) || (r_out.event_res == EV_SUM_BAD))))
        else $error("body closed without verdict");
`endif

endmodule

// ----- hw/rtl/hex_image_upload_receiver.sv -----
// top level of the hex image upload receiver
// usage:
//   input channel: one raw link byte per beat on i_rx_byte, handshake
//   i_in_valid / o_in_ready
//   output channel: exactly one result beat per input beat, handshake
//   o_out_valid / i_out_ready; a beat carries an event code, an optional
//   decoded image byte with its index, and the last accepted image length
//   outside an image, bytes form text lines; a "!SLT <len> <sum>" line opens
//   an image body, where hex digit pairs become bytes, and '!' closes it
//   an accepted byte passes through the queue and then the result register
//   before its result beat can be offered on the output
//   throughput: one byte per cycle sustained while i_out_ready stays high; the
//   back end does each byte's line/body update combinationally, bounded by
//   the 32-bit decimal accumulate (times ten plus digit)
//   reset clears the queue, the parser and the result valid flag; no result
//   is pending after reset and the first image length reported is zero
//   when the receiver stalls, the result register holds its beat, the back
//   end stops, the two-entry queue fills and then o_in_ready drops
module hex_image_upload_receiver import hiur_pkg::*; #(
    parameter int MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF,
    parameter int LINE_BYTES      = LINE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic        o_data_valid,
    output logic [13:0] o_data_index,
    output logic [7:0]  o_data_value,
    output logic [14:0] o_image_length
);

    // front to queue
    logic w_push, w_q_full;
    t_cls w_cls_in;

    // queue to back
    logic w_q_valid, w_pop;
    t_cls w_cls_out;

    t_res w_res;

    // classify each byte as it arrives
    hiur_front u_front (
        .i_valid  (i_in_valid),
        .i_byte   (i_rx_byte),
        .i_q_full (w_q_full),
        .o_ready  (o_in_ready),
        .o_push   (w_push),
        .o_cls    (w_cls_in)
    );

    // decouples intake from the parser so either side can stall
    hiur_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cls_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_cls_out)
    );

    // line parser, body decoder, result register
    hiur_back #(
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES),
        .LINE_BYTES      (LINE_BYTES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_cls     (w_cls_out),
        .o_pop     (w_pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_res     (w_res)
    );

    assign o_event_res    = w_res.event_res;
    assign o_data_valid   = w_res.data_valid;
    assign o_data_index   = w_res.data_index;
    assign o_data_value   = w_res.data_value;
    assign o_image_length = w_res.image_length;

endmodule

// ----- tb/tb_hex_image_upload_receiver.sv -----
// self-checking testbench of the hex image upload receiver
module tb_hex_image_upload_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import hiur_pkg::*;

    // cycles without any handshake before the run is declared hung; far longer than any
    // receiver hold or sender gap, so this is generous
    localparam int WATCHDOG_LIMIT = 5000;
    // random part length, counted in link bytes
    localparam int RANDOM_BYTES   = 650;
    // first mismatches printed in full, the rest only counted
    localparam int PRINT_LIMIT    = 20;

    // receiver stall styles
    localparam int RDY_OPEN     = 0;
    localparam int RDY_COIN     = 1;
    localparam int RDY_PERIODIC = 2;
    localparam int RDY_HOLD     = 3;

    // ---------------------------------------------------------------------
    // scoreboard: own copy of the parser and body decoder, one expected
    // result beat per accepted link byte
    // ---------------------------------------------------------------------
    class upload_scoreboard;
        // line side
        bit          body_open;
        int unsigned line_len;
        bit          line_ended;   // a zero byte stopped parsing of this line
        logic [2:0]  prefix_seen;
        logic [2:0]  num_phase;
        logic [31:0] len_acc;
        logic [31:0] sum_acc;
        // body side
        logic [31:0] hdr_len;
        logic [31:0] hdr_sum;
        logic [31:0] byte_count;
        logic [31:0] byte_sum;
        logic [3:0]  hi_nib;
        bit          nib_pending;
        logic [31:0] last_len;

        logic [7:0]  hdr_tag [4] = '{CH_BANG, CH_S, CH_L, CH_T};

        t_res        results_due[$];
        int unsigned errors;
        int unsigned beats_checked;
        int unsigned data_beats;
        int unsigned longest_ok;
        int unsigned ev_seen [8];

        function new();
            body_open   = 1'b0;
            restart_line();
            hdr_len     = '0;
            hdr_sum     = '0;
            byte_count  = '0;
            byte_sum    = '0;
            hi_nib      = '0;
            nib_pending = 1'b0;
            last_len    = '0;
            errors      = 0;
        endfunction

        function void restart_line();
            line_len    = 0;
            line_ended  = 1'b0;
            prefix_seen = PF_NONE;
            num_phase   = NP_PRE_LEN;
            len_acc     = '0;
            sum_acc     = '0;
        endfunction

        function bit hex_nibble(logic [7:0] c, output logic [3:0] v);
            v = '0;
            if (c >= CH_0 && c <= CH_9) v = 4'(c - CH_0);
            else if (c >= CH_LA && c <= CH_LF) v = 4'(c - CH_LA + 8'd10);
            else if (c >= CH_UA && c <= CH_UF) v = 4'(c - CH_UA + 8'd10);
            else return 1'b0;
            return 1'b1;
        endfunction

        // one stored character of a text line
        function void scan_char(logic [7:0] c);
            logic        is_dec;
            logic [31:0] d;
            is_dec = (c >= CH_0 && c <= CH_9);
            d      = 32'(c - CH_0);
            if (c == CH_NUL) begin
                line_ended = 1'b1;
                return;
            end
            if (prefix_seen < PF_HEADER) begin
                prefix_seen = (c == hdr_tag[prefix_seen[1:0]]) ? prefix_seen + 3'd1 : PF_NOT_HDR;
                return;
            end
            if (prefix_seen != PF_HEADER) return;
            case (num_phase)
                NP_PRE_LEN: begin
                    if (is_dec) begin
                        len_acc   = d;
                        num_phase = NP_LEN;
                    end else if (c != CH_SPACE) begin
                        num_phase = NP_DONE;
                    end
                end
                NP_LEN: begin
                    if (is_dec) len_acc = len_acc * DEC_BASE + d;
                    else num_phase = (c == CH_SPACE) ? NP_PRE_SUM : NP_DONE;
                end
                NP_PRE_SUM: begin
                    if (is_dec) begin
                        sum_acc   = d;
                        num_phase = NP_SUM;
                    end else if (c != CH_SPACE) begin
                        num_phase = NP_DONE;
                    end
                end
                NP_SUM: begin
                    if (is_dec) sum_acc = sum_acc * DEC_BASE + d;
                    else num_phase = NP_DONE;
                end
                default: ;
            endcase
        endfunction

        function logic [2:0] close_line();
            logic [2:0] ev;
            ev = EV_NONE;
            if (prefix_seen == PF_HEADER) begin
                if (len_acc == 0 || len_acc > MAX_IMAGE_BYTES_DEF) begin
                    ev = EV_HDR_BAD;
                end else begin
                    hdr_len     = len_acc;
                    hdr_sum     = sum_acc;
                    byte_count  = '0;
                    byte_sum    = '0;
                    nib_pending = 1'b0;
                    body_open   = 1'b1;
                    ev          = EV_HDR_OK;
                end
            end
            restart_line();
            return ev;
        endfunction

        function t_res decode_byte(logic [7:0] c);
            t_res       r;
            logic [3:0] nib;
            r = '0;
            if (!body_open) begin
                // a full line buffer ends the line and swallows the byte
                if (c == CH_NL || line_len + 1 >= LINE_BYTES_DEF) begin
                    r.event_res = close_line();
                end else if (c != CH_CR) begin
                    line_len++;
                    if (!line_ended) scan_char(c);
                end
            end else if (c == CH_BANG) begin
                body_open   = 1'b0;
                nib_pending = 1'b0;
                restart_line();
                // the closing bang is already the first character of the next line
                line_len    = 1;
                prefix_seen = PF_ONE;
                if (byte_count != hdr_len) begin
                    r.event_res = EV_LEN_BAD;
                end else if (byte_sum != hdr_sum) begin
                    r.event_res = EV_SUM_BAD;
                end else begin
                    last_len    = byte_count;
                    r.event_res = EV_IMG_OK;
                end
            end else if (hex_nibble(c, nib)) begin
                if (!nib_pending) begin
                    hi_nib      = nib;
                    nib_pending = 1'b1;
                end else begin
                    nib_pending = 1'b0;
                    // past the size cap bytes are decoded but dropped
                    if (byte_count < MAX_IMAGE_BYTES_DEF) begin
                        r.data_valid = 1'b1;
                        r.data_index = byte_count[13:0];
                        r.data_value = {hi_nib, nib};
                        byte_count++;
                        byte_sum += {24'd0, hi_nib, nib};
                    end
                end
            end
            r.image_length = last_len[14:0];
            return r;
        endfunction

        function void note_byte(logic [7:0] c);
            results_due.push_back(decode_byte(c));
        endfunction

        task report(string what);
            errors++;
            if (errors <= PRINT_LIMIT) $display("mismatch: %s", what);
        endtask

        task check_beat(t_res got);
            t_res want;
            beats_checked++;
            if (results_due.size() == 0) begin
                report($sformatf("beat %0d arrived with nothing expected", beats_checked));
                return;
            end
            want = results_due.pop_front();
            if (got.event_res != want.event_res)
                report($sformatf("beat %0d event_res %0d, expected %0d",
                                 beats_checked, got.event_res, want.event_res));
            if (got.data_valid != want.data_valid)
                report($sformatf("beat %0d data_valid %0d, expected %0d",
                                 beats_checked, got.data_valid, want.data_valid));
            if (got.data_index != want.data_index)
                report($sformatf("beat %0d data_index %0d, expected %0d",
                                 beats_checked, got.data_index, want.data_index));
            if (got.data_value != want.data_value)
                report($sformatf("beat %0d data_value 0x%02h, expected 0x%02h",
                                 beats_checked, got.data_value, want.data_value));
            if (got.image_length != want.image_length)
                report($sformatf("beat %0d image_length %0d, expected %0d",
                                 beats_checked, got.image_length, want.image_length));
            ev_seen[want.event_res]++;
            if (want.data_valid) data_beats++;
            if (want.event_res == EV_IMG_OK && want.image_length > longest_ok)
                longest_ok = want.image_length;
        endtask

        task flag_leftovers();
            if (results_due.size() != 0)
                report($sformatf("%0d expected beats never arrived", results_due.size()));
        endtask
    endclass

    // ---------------------------------------------------------------------
    // clock, reset, dut
    // ---------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [2:0]  o_event_res;
    logic        o_data_valid;
    logic [13:0] o_data_index;
    logic [7:0]  o_data_value;
    logic [14:0] o_image_length;

    always #5 i_clk = ~i_clk;

    hex_image_upload_receiver u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_data_valid   (o_data_valid),
        .o_data_index   (o_data_index),
        .o_data_value   (o_data_value),
        .o_image_length (o_image_length)
    );

    upload_scoreboard sb;

    int         bytes_sent  = 0;
    int         bytes_noted = 0;
    int         burst_left  = 0;
    int         idle_cycles = 0;
    logic [7:0] outbox[$];

    // ---------------------------------------------------------------------
    // monitor: notes input beats and checks output beats at the same edge,
    // inputs first so the order within a step never matters
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_res got;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                sb.note_byte(i_rx_byte);
                bytes_noted++;
            end
            if (o_out_valid && i_out_ready) begin
                got.event_res    = o_event_res;
                got.data_valid   = o_data_valid;
                got.data_index   = o_data_index;
                got.data_value   = o_data_value;
                got.image_length = o_image_length;
                sb.check_beat(got);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog: a hung handshake ends the run
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------------
    // receiver: switches between stall styles so gaps hit every phase
    // ---------------------------------------------------------------------
    initial begin : receiver
        int style;
        int span;
        int period;
        wait (i_rst_n === 1'b1);
        forever begin
            style  = $urandom_range(RDY_OPEN, RDY_HOLD);
            span   = (style == RDY_HOLD) ? $urandom_range(10, 40) : $urandom_range(20, 200);
            period = $urandom_range(2, 5);
            for (int c = 0; c < span; c++) begin
                @(negedge i_clk);
                case (style)
                    RDY_OPEN:     i_out_ready <= 1'b1;
                    RDY_COIN:     i_out_ready <= 1'($urandom_range(0, 1));
                    RDY_PERIODIC: i_out_ready <= (c % period == 0);
                    default:      i_out_ready <= 1'b0;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // sender: bursts of beats with random gaps in between
    // ---------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 24) : $urandom_range(1, 6);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            // some bursts are long enough to count as no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 300)
                                                     : $urandom_range(1, 16);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        bytes_sent++;
    endtask

    // send what is queued, then let the monitor catch up so that the
    // scoreboard state can steer the next choice
    task automatic send_outbox();
        while (outbox.size() != 0) push_byte(outbox.pop_front());
        wait (bytes_noted == bytes_sent);
    endtask

    // ---------------------------------------------------------------------
    // text builders
    // ---------------------------------------------------------------------
    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) outbox.push_back(s[i]);
    endfunction

    function automatic void add_spaces(int k);
        repeat (k) outbox.push_back(CH_SPACE);
    endfunction

    function automatic void add_decimal(logic [63:0] v);
        add_text($sformatf("%0d", v));
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'(CH_0 + n);
        return 8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + (n - 4'd10));
    endfunction

    // any byte the body skips over
    function automatic logic [7:0] body_noise();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255));
        while ((v >= CH_0 && v <= CH_9) || (v >= CH_UA && v <= CH_UF) ||
               (v >= CH_LA && v <= CH_LF) || v == CH_BANG);
        return v;
    endfunction

    function automatic logic [7:0] line_byte();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (v == CH_NL);
        return v;
    endfunction

    function automatic void add_hex_pair(logic [7:0] b);
        outbox.push_back(hex_char(b[7:4]));
        if ($urandom_range(0, 11) == 0) outbox.push_back(body_noise());
        outbox.push_back(hex_char(b[3:0]));
        if ($urandom_range(0, 11) == 0) outbox.push_back(body_noise());
    endfunction

    // start a header line: a bang left over from a body end is reused,
    // a half line of junk is flushed first
    function automatic void open_header();
        if (sb.line_len == 0) begin
            outbox.push_back(CH_BANG);
        end else if (!(sb.line_len == 1 && sb.prefix_seen == PF_ONE)) begin
            outbox.push_back(CH_NL);
            outbox.push_back(CH_BANG);
        end
    endfunction

    // ---------------------------------------------------------------------
    // sequences
    // ---------------------------------------------------------------------
    task automatic send_short_body();
        int pairs;
        pairs = $urandom_range(0, 5);
        repeat (pairs) add_hex_pair(8'($urandom));
        if ($urandom_range(0, 3) == 0) outbox.push_back(hex_char(4'($urandom)));
        outbox.push_back(CH_BANG);
        send_outbox();
    endtask

    // header plus body; mostly consistent, sometimes with a wrong length or sum,
    // sometimes with numbers that only fit after wrapping at 32 bits
    task automatic send_upload(input int n, input bit oversize);
        logic [7:0]  img[$];
        logic [31:0] sum;
        logic [63:0] len_txt;
        logic [63:0] sum_txt;
        int          roll;
        sum = '0;
        for (int i = 0; i < n; i++) begin
            img.push_back(8'($urandom));
            if (i < MAX_IMAGE_BYTES_DEF) sum += img[i];
        end
        len_txt = oversize ? 64'(MAX_IMAGE_BYTES_DEF) : 64'(n);
        sum_txt = 64'(sum);
        if (!oversize) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) sum_txt = 64'(sum + $urandom_range(1, 500));
            else if (roll < 22) len_txt = (n > 1 && $urandom_range(0, 1)) ? 64'(n - 1) : 64'(n + 1);
            if ($urandom_range(0, 9) == 0) len_txt += {32'($urandom_range(1, 3)), 32'd0};
            if ($urandom_range(0, 9) == 0) sum_txt += {32'($urandom_range(1, 7)), 32'd0};
        end
        open_header();
        add_text("SLT");
        add_spaces($urandom_range(0, 3));
        add_decimal(len_txt);
        add_spaces($urandom_range(1, 3));
        add_decimal(sum_txt);
        if ($urandom_range(0, 3) == 0) add_spaces($urandom_range(1, 2));
        if ($urandom_range(0, 2) == 0) outbox.push_back(CH_CR);
        // a stray carriage return anywhere in the line is skipped
        if ($urandom_range(0, 4) == 0) outbox.insert($urandom_range(0, outbox.size() - 1), CH_CR);
        outbox.push_back(CH_NL);
        send_outbox();
        if (!sb.body_open) return;
        foreach (img[i]) add_hex_pair(img[i]);
        // dangling half byte at the end is dropped
        if ($urandom_range(0, 9) == 0) outbox.push_back(hex_char(4'($urandom)));
        outbox.push_back(CH_BANG);
        send_outbox();
    endtask

    task automatic send_bad_header();
        open_header();
        add_text("SLT");
        add_spaces($urandom_range(1, 2));
        case ($urandom_range(0, 5))
            0: add_decimal(64'd0);
            1: add_decimal(64'(MAX_IMAGE_BYTES_DEF + 1));
            2: add_decimal(64'($urandom_range(MAX_IMAGE_BYTES_DEF + 1, 32'hFFFF_FFFF)));
            3: ;
            4: add_decimal({32'($urandom_range(1, 5)), 32'd0});   // wraps to zero
            default: begin
                outbox.push_back(8'h78);
                add_decimal(64'($urandom_range(1, 99)));
            end
        endcase
        if ($urandom_range(0, 1)) begin
            add_spaces(1);
            add_decimal(64'($urandom));
        end
        outbox.push_back(CH_NL);
        send_outbox();
    endtask

    task automatic send_text_line();
        int len;
        len = $urandom_range(0, 30);
        repeat (len) outbox.push_back(line_byte());
        outbox.push_back(CH_NL);
        send_outbox();
    endtask

    // longer than the line buffer: either plain junk or a header padded out
    task automatic send_long_line();
        int len;
        len = $urandom_range(64, 85);
        if ($urandom_range(0, 1)) begin
            open_header();
            add_text("SLT ");
            add_decimal(64'($urandom_range(1, 6)));
            add_spaces(1);
            add_decimal(64'($urandom_range(0, 1500)));
            while (outbox.size() < len) outbox.push_back(CH_SPACE);
        end else begin
            repeat (len) outbox.push_back(line_byte());
        end
        if ($urandom_range(0, 3) != 0) outbox.push_back(CH_NL);
        send_outbox();
    endtask

    // zero byte somewhere in a header: the rest of the line is not parsed
    task automatic send_nul_line();
        int start;
        open_header();
        start = outbox.size();
        add_text("SLT ");
        add_decimal(64'($urandom_range(1, 9)));
        add_spaces(1);
        add_decimal(64'($urandom_range(0, 999)));
        outbox.insert($urandom_range(start, outbox.size()), CH_NUL);
        add_decimal(64'($urandom_range(0, 99)));
        outbox.push_back(CH_NL);
        send_outbox();
    endtask

    task automatic send_noise();
        int len;
        len = $urandom_range(1, 8);
        repeat (len) outbox.push_back(8'($urandom));
        send_outbox();
    endtask

    // marker cut short or broken
    task automatic send_partial_marker();
        int keep;
        open_header();
        keep = $urandom_range(0, 3);
        if (keep > 0) outbox.push_back(CH_S);
        if (keep > 1) outbox.push_back(CH_L);
        if (keep > 2) outbox.push_back(CH_T);
        if ($urandom_range(0, 1)) outbox.push_back(8'($urandom_range(8'h41, 8'h5A)));
        if ($urandom_range(0, 1)) add_text(" 3 9");
        outbox.push_back(CH_NL);
        send_outbox();
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin : stimulus
        int roll;
        int stop_at;
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one byte image with crlf header, byte ff in mixed case,
        // bang reused as next line start with a zero length, then the two
        // byte extremes on a plain line
        add_text("!SLT 1 255");
        outbox.push_back(CH_CR);
        outbox.push_back(CH_NL);
        add_text("fF!SLT 0");
        outbox.push_back(CH_NL);
        outbox.push_back(8'hFF);
        outbox.push_back(CH_NUL);
        outbox.push_back(CH_NL);
        send_outbox();

        // random: mostly well-formed uploads, the rest malformed lines and noise
        stop_at = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < stop_at) begin
            if (sb.body_open) send_short_body();
            roll = $urandom_range(0, 99);
            if (roll < 55)
                send_upload(($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                        : $urandom_range(1, 8), 1'b0);
            else if (roll < 65) send_bad_header();
            else if (roll < 73) send_text_line();
            else if (roll < 79) send_long_line();
            else if (roll < 85) send_nul_line();
            else if (roll < 92) send_noise();
            else send_partial_marker();
        end
        if (sb.body_open) send_short_body();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        sb.flag_leftovers();

        $display("covered %0d link bytes, %0d result beats, %0d decoded bytes, largest image %0d",
                 bytes_sent, sb.beats_checked, sb.data_beats, sb.longest_ok);
        $display("headers ok %0d / rejected %0d, images ok %0d / short-long %0d / bad sum %0d",
                 sb.ev_seen[EV_HDR_OK], sb.ev_seen[EV_HDR_BAD], sb.ev_seen[EV_IMG_OK],
                 sb.ev_seen[EV_LEN_BAD], sb.ev_seen[EV_SUM_BAD]);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/hiur_pkg.sv
hw/rtl/hiur_front.sv
hw/rtl/hiur_queue.sv
hw/rtl/hiur_back.sv
hw/rtl/hex_image_upload_receiver.sv
tb/tb_hex_image_upload_receiver.sv
